// ===== rtl/bba_pkg.sv =====
// Shared types and constants of the buddy block allocator.
// Holds the controller states, the datapath command and status structs.
// No dependencies.
package bba_pkg;

    localparam int POOL_ORDER_DEF   = 10;
    localparam int MIN_ORDER_DEF    = 1;
    localparam int HEADER_BYTES_DEF = 8;
    localparam int REQ_W            = 10;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SPLIT,
        ST_FREE_ORD,
        ST_MERGE_RD,
        ST_MERGE_CHK,
        ST_RESP
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LATCH,
        DP_SCAN_START,
        DP_SCAN_RD,
        DP_TAKE,
        DP_SCAN_NEXT_IDX,
        DP_SCAN_NEXT_LVL,
        DP_SPLIT,
        DP_ALLOC_DONE,
        DP_FAIL,
        DP_ORD_RD,
        DP_FREE_START,
        DP_MERGE_RD,
        DP_MERGE,
        DP_FREE_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic alloc_bad;
        logic free_bad;
        logic fm_bit;
        logic ord_ok;
        logic idx_last;
        logic lvl_top;
        logic at_tgt;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator: top level joining controller and datapath.
// Depends on bba_pkg, bba_ctrl and bba_datapath.
//
// Request channel (i_req_valid / o_req_ready) carries one item: a type bit
// (allocate or free), a size for allocate and an address for free. The
// response channel (o_rsp_valid / i_rsp_ready) returns one item per request:
// the block address plus header on a successful allocate, else zero, and ok.
// Pool order must exceed the minimum block order.
// After reset the block runs a clearing pass over the free bitmap, one entry
// a cycle, during which no request is accepted.
// One request is worked on at a time. An allocate scans the free bitmap
// entries from the target level upward and splits the block it takes down
// to the target level; a free reads the block order and merges with free
// buddies level by level. The free bitmap memory has a registered read.
// The result sits in an output register; when the receiver stalls, the
// finished request waits for that register and no new request is taken.
module buddy_block_allocator #(
    parameter int POOL_ORDER   = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_req_valid,
    output logic                      o_req_ready,
    input  logic                      i_req_type,
    input  logic [bba_pkg::REQ_W-1:0] i_req_size,
    input  logic [bba_pkg::REQ_W-1:0] i_free_addr,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output logic [bba_pkg::REQ_W-1:0] o_block_addr,
    output logic                      o_ok
);

    bba_pkg::t_dp_cmd  cmd;
    bba_pkg::t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    bba_datapath #(
        .POOL_ORDER   (POOL_ORDER),
        .MIN_ORDER    (MIN_ORDER),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_req_size   (i_req_size),
        .i_free_addr  (i_free_addr),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_block_addr (o_block_addr),
        .o_ok         (o_ok)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while another is in progress");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_ok) |-> (o_block_addr == '0))
        else $error("failed request returned a nonzero address");

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == bba_pkg::DP_CLEAR) |-> !o_req_ready)
        else $error("request ready during clearing pass");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_rsp_valid || i_rsp_ready))
        else $error("output register overwritten before it was taken");
`endif

endmodule

// ===== rtl/bba_ctrl.sv =====
// Controller state machine of the buddy block allocator.
// Sequences clearing, scan, split and merge steps; uses bba_pkg.
module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_dp_cmd  o_cmd
);

    bba_pkg::t_state r_state;
    bba_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = bba_pkg::DP_NOP;
        o_cmd.load_out = 1'b0;
        o_req_ready    = 1'b0;
        unique case (r_state)
            bba_pkg::ST_CLEAR: begin
                o_cmd.op = bba_pkg::DP_CLEAR;
                if (i_stat.clr_last) begin
                    n_state = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.op = bba_pkg::DP_LATCH;
                    n_state  = bba_pkg::ST_DECODE;
                end
            end
            bba_pkg::ST_DECODE: begin
                if (i_stat.is_free) begin
                    if (i_stat.free_bad) begin
                        o_cmd.op = bba_pkg::DP_FAIL;
                        n_state  = bba_pkg::ST_RESP;
                    end else begin
                        o_cmd.op = bba_pkg::DP_ORD_RD;
                        n_state  = bba_pkg::ST_FREE_ORD;
                    end
                end else if (i_stat.alloc_bad) begin
                    o_cmd.op = bba_pkg::DP_FAIL;
                    n_state  = bba_pkg::ST_RESP;
                end else begin
                    o_cmd.op = bba_pkg::DP_SCAN_START;
                    n_state  = bba_pkg::ST_SCAN_RD;
                end
            end
            bba_pkg::ST_SCAN_RD: begin
                o_cmd.op = bba_pkg::DP_SCAN_RD;
                n_state  = bba_pkg::ST_SCAN_CHK;
            end
            bba_pkg::ST_SCAN_CHK: begin
                if (i_stat.fm_bit) begin
                    o_cmd.op = bba_pkg::DP_TAKE;
                    n_state  = bba_pkg::ST_SPLIT;
                end else if (!i_stat.idx_last) begin
                    o_cmd.op = bba_pkg::DP_SCAN_NEXT_IDX;
                    n_state  = bba_pkg::ST_SCAN_RD;
                end else if (!i_stat.lvl_top) begin
                    o_cmd.op = bba_pkg::DP_SCAN_NEXT_LVL;
                    n_state  = bba_pkg::ST_SCAN_RD;
                end else begin
                    o_cmd.op = bba_pkg::DP_FAIL;
                    n_state  = bba_pkg::ST_RESP;
                end
            end
            bba_pkg::ST_SPLIT: begin
                if (i_stat.at_tgt) begin
                    o_cmd.op = bba_pkg::DP_ALLOC_DONE;
                    n_state  = bba_pkg::ST_RESP;
                end else begin
                    o_cmd.op = bba_pkg::DP_SPLIT;
                end
            end
            bba_pkg::ST_FREE_ORD: begin
                if (i_stat.ord_ok) begin
                    o_cmd.op = bba_pkg::DP_FREE_START;
                    n_state  = bba_pkg::ST_MERGE_RD;
                end else begin
                    o_cmd.op = bba_pkg::DP_FAIL;
                    n_state  = bba_pkg::ST_RESP;
                end
            end
            bba_pkg::ST_MERGE_RD: begin
                if (i_stat.lvl_top) begin
                    o_cmd.op = bba_pkg::DP_FREE_DONE;
                    n_state  = bba_pkg::ST_RESP;
                end else begin
                    o_cmd.op = bba_pkg::DP_MERGE_RD;
                    n_state  = bba_pkg::ST_MERGE_CHK;
                end
            end
            bba_pkg::ST_MERGE_CHK: begin
                if (i_stat.fm_bit) begin
                    o_cmd.op = bba_pkg::DP_MERGE;
                    n_state  = bba_pkg::ST_MERGE_RD;
                end else begin
                    o_cmd.op = bba_pkg::DP_FREE_DONE;
                    n_state  = bba_pkg::ST_RESP;
                end
            end
            bba_pkg::ST_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = bba_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bba_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/bba_datapath.sv =====
// Datapath of the buddy block allocator: free bitmap and block order memories,
// level and index registers, request decode and the output register. Uses bba_pkg.
module bba_datapath #(
    parameter int POOL_ORDER   = bba_pkg::POOL_ORDER_DEF,
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bba_pkg::t_dp_cmd          i_cmd,
    output bba_pkg::t_dp_stat         o_stat,
    input  logic                      i_req_type,
    input  logic [bba_pkg::REQ_W-1:0] i_req_size,
    input  logic [bba_pkg::REQ_W-1:0] i_free_addr,
    output logic                      o_rsp_valid,
    input  logic                      i_rsp_ready,
    output logic [bba_pkg::REQ_W-1:0] o_block_addr,
    output logic                      o_ok
);

    localparam int RW  = bba_pkg::REQ_W;
    localparam int L   = POOL_ORDER - MIN_ORDER + 1;
    localparam int FAW = L;
    localparam int FD  = (1 << L) - 1;
    localparam int SW  = POOL_ORDER - MIN_ORDER;
    localparam int OD  = 1 << SW;
    localparam int LW  = $clog2(L);
    localparam int OW  = $clog2(POOL_ORDER + 1);
    localparam int XW  = POOL_ORDER + 8;

    logic            r_free_map [0:FD-1];
    logic [OW:0]     r_order    [0:OD-1];

    logic [FAW-1:0]  r_clr;
    logic            r_type;
    logic [RW-1:0]   r_size;
    logic [RW-1:0]   r_faddr;
    logic [LW-1:0]   r_lvl;
    logic [SW-1:0]   r_idx;
    logic [OW-1:0]   r_k;
    logic            r_fm_q;
    logic [OW:0]     r_om_q;
    logic [RW-1:0]   r_res_addr;
    logic            r_res_ok;
    logic            r_out_valid;
    logic [RW-1:0]   r_out_addr;
    logic            r_out_ok;

    logic [RW:0]     total;
    logic [RW:0]     tm1;
    logic [3:0]      kneed;
    logic [OW-1:0]   k_calc;
    logic [LW-1:0]   tgt;
    logic [RW-1:0]   off;
    logic [SW-1:0]   slot;
    logic [OW-1:0]   k_mem;
    logic [SW:0]     cnt_m1;
    logic [SW-1:0]   idx_up;
    logic [SW-1:0]   mate;
    logic [XW-1:0]   blk_off;

    logic            fm_we;
    logic [FAW-1:0]  fm_waddr;
    logic            fm_wdata;
    logic            fm_re;
    logic [FAW-1:0]  fm_raddr;
    logic            om_we;
    logic [SW-1:0]   om_waddr;
    logic [OW:0]     om_wdata;
    logic            om_re;

    function automatic logic [FAW-1:0] fm_addr(input logic [LW-1:0] lvl,
                                               input logic [SW-1:0] idx);
        logic [FAW-1:0] base;
        base    = (FAW'(1) << (L - 1 - int'(lvl))) - FAW'(1);
        fm_addr = base + FAW'(idx);
    endfunction

    always_comb begin
        total = (RW + 1)'(r_size) + (RW + 1)'(HEADER_BYTES);
        tm1   = (total == '0) ? '0 : total - (RW + 1)'(1);
        kneed = '0;
        for (int i = 0; i <= RW; i++) begin
            if (tm1[i]) begin
                kneed = 4'(i + 1);
            end
        end
        k_calc  = (int'(kneed) < MIN_ORDER) ? OW'(MIN_ORDER) : OW'(kneed);
        tgt     = LW'(int'(r_k) - MIN_ORDER);
        off     = r_faddr - RW'(HEADER_BYTES);
        slot    = SW'(off >> MIN_ORDER);
        k_mem   = r_om_q[OW-1:0];
        cnt_m1  = ((SW + 1)'(1) << (L - 1 - int'(r_lvl))) - (SW + 1)'(1);
        idx_up  = SW'({r_idx, 1'b1});
        mate    = r_idx ^ SW'(1);
        blk_off = XW'(r_idx) << (MIN_ORDER + int'(r_lvl));
    end

    always_comb begin
        o_stat.clr_last  = (r_clr == FAW'(FD - 1));
        o_stat.is_free   = r_type;
        o_stat.alloc_bad = (int'(kneed) > POOL_ORDER);
        o_stat.free_bad  = (int'(r_faddr) < HEADER_BYTES)
                        || (((RW + 1)'(off) >> POOL_ORDER) != '0)
                        || ((off & RW'((1 << MIN_ORDER) - 1)) != '0);
        o_stat.fm_bit    = r_fm_q;
        o_stat.ord_ok    = r_om_q[OW] && (int'(k_mem) >= MIN_ORDER)
                        && (int'(k_mem) <= POOL_ORDER);
        o_stat.idx_last  = (r_idx == cnt_m1[SW-1:0]);
        o_stat.lvl_top   = (int'(r_lvl) == L - 1);
        o_stat.at_tgt    = (r_lvl == tgt);
        o_stat.out_free  = !r_out_valid || i_rsp_ready;
    end

    always_comb begin
        fm_we    = 1'b0;
        fm_waddr = fm_addr(r_lvl, r_idx);
        fm_wdata = 1'b0;
        fm_re    = 1'b0;
        fm_raddr = fm_addr(r_lvl, r_idx);
        om_we    = 1'b0;
        om_waddr = slot;
        om_wdata = '0;
        om_re    = 1'b0;
        case (i_cmd.op)
            bba_pkg::DP_CLEAR: begin
                fm_we    = 1'b1;
                fm_waddr = r_clr;
                fm_wdata = (r_clr == '0);
                om_we    = (int'(r_clr) < OD);
                om_waddr = SW'(r_clr);
            end
            bba_pkg::DP_SCAN_RD: begin
                fm_re = 1'b1;
            end
            bba_pkg::DP_TAKE: begin
                fm_we = 1'b1;
            end
            bba_pkg::DP_SPLIT: begin
                fm_we    = 1'b1;
                fm_waddr = fm_addr(r_lvl - LW'(1), idx_up);
                fm_wdata = 1'b1;
            end
            bba_pkg::DP_ALLOC_DONE: begin
                om_we    = 1'b1;
                om_waddr = SW'(blk_off >> MIN_ORDER);
                om_wdata = {1'b1, r_k};
            end
            bba_pkg::DP_ORD_RD: begin
                om_re = 1'b1;
            end
            bba_pkg::DP_FREE_START: begin
                om_we = 1'b1;
            end
            bba_pkg::DP_MERGE_RD: begin
                fm_re    = 1'b1;
                fm_raddr = fm_addr(r_lvl, mate);
            end
            bba_pkg::DP_MERGE: begin
                fm_we    = 1'b1;
                fm_waddr = fm_addr(r_lvl, mate);
            end
            bba_pkg::DP_FREE_DONE: begin
                fm_we    = 1'b1;
                fm_wdata = 1'b1;
            end
            default: begin
                fm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_free_map[fm_waddr] <= fm_wdata;
        end
        if (fm_re) begin
            r_fm_q <= r_free_map[fm_raddr];
        end
        if (om_we) begin
            r_order[om_waddr] <= om_wdata;
        end
        if (om_re) begin
            r_om_q <= r_order[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bba_pkg::DP_LATCH: begin
                r_type  <= i_req_type;
                r_size  <= i_req_size;
                r_faddr <= i_free_addr;
            end
            bba_pkg::DP_SCAN_START: begin
                r_k   <= k_calc;
                r_lvl <= LW'(int'(k_calc) - MIN_ORDER);
                r_idx <= '0;
            end
            bba_pkg::DP_SCAN_NEXT_IDX: begin
                r_idx <= r_idx + SW'(1);
            end
            bba_pkg::DP_SCAN_NEXT_LVL: begin
                r_lvl <= r_lvl + LW'(1);
                r_idx <= '0;
            end
            bba_pkg::DP_SPLIT: begin
                r_lvl <= r_lvl - LW'(1);
                r_idx <= SW'({r_idx, 1'b0});
            end
            bba_pkg::DP_ALLOC_DONE: begin
                r_res_addr <= RW'(blk_off + XW'(HEADER_BYTES));
                r_res_ok   <= 1'b1;
            end
            bba_pkg::DP_FAIL: begin
                r_res_addr <= '0;
                r_res_ok   <= 1'b0;
            end
            bba_pkg::DP_FREE_START: begin
                r_lvl <= LW'(int'(k_mem) - MIN_ORDER);
                r_idx <= SW'(off >> k_mem);
            end
            bba_pkg::DP_MERGE: begin
                r_lvl <= r_lvl + LW'(1);
                r_idx <= r_idx >> 1;
            end
            bba_pkg::DP_FREE_DONE: begin
                r_res_addr <= '0;
                r_res_ok   <= 1'b1;
            end
            default: begin
                r_lvl <= r_lvl;
            end
        endcase
        if (i_cmd.load_out) begin
            r_out_addr <= r_res_addr;
            r_out_ok   <= r_res_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == bba_pkg::DP_CLEAR) begin
                r_clr <= r_clr + FAW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid  = r_out_valid;
    assign o_block_addr = r_out_addr;
    assign o_ok         = r_out_ok;

endmodule

// ===== tb/sv/tb_buddy_block_allocator.sv =====
// Self-checking testbench for the buddy block allocator: drives allocate and
// free requests, predicts each result with its own buddy model and compares.
// Depends on bba_pkg and the buddy_block_allocator RTL.
`timescale 1ns / 1ps

class alloc_scoreboard;
    localparam int POOL   = bba_pkg::POOL_ORDER_DEF;
    localparam int MINO   = bba_pkg::MIN_ORDER_DEF;
    localparam int HDR    = bba_pkg::HEADER_BYTES_DEF;
    localparam int LEVELS = POOL - MINO + 1;
    localparam int SLOTS  = 1 << (POOL - MINO);

    bit          free_bits[LEVELS][];
    bit [3:0]    slot_order[SLOTS];
    bit          slot_live[SLOTS];
    bit [9:0]    exp_addr_q[$];
    bit          exp_ok_q[$];
    int          errors;
    bit [9:0]    live_addrs[$];

    function new();
        for (int l = 0; l < LEVELS; l++) begin
            free_bits[l] = new[1 << (LEVELS - 1 - l)];
            foreach (free_bits[l][i]) free_bits[l][i] = 0;
        end
        free_bits[LEVELS-1][0] = 1;
        foreach (slot_live[i]) slot_live[i] = 0;
        errors = 0;
    endfunction

    function void note_request(bit is_free, bit [9:0] size, bit [9:0] addr);
        int total, k, tgt, lvl, idx, off, fo, mate;
        bit found;
        bit [9:0] ra;
        bit rok;
        ra = 0;
        rok = 0;
        found = 0;
        idx = 0;
        if (!is_free) begin
            total = size + HDR;
            k = MINO;
            while ((1 << k) < total && k < POOL) k++;
            if ((1 << k) >= total) begin
                tgt = k - MINO;
                for (lvl = tgt; lvl < LEVELS; lvl++) begin
                    for (idx = 0; idx < free_bits[lvl].size(); idx++)
                        if (free_bits[lvl][idx]) begin
                            found = 1;
                            break;
                        end
                    if (found) break;
                end
                if (found) begin
                    off = idx << (MINO + lvl);
                    free_bits[lvl][idx] = 0;
                    while (lvl > tgt) begin
                        lvl--;
                        free_bits[lvl][(off >> (MINO + lvl)) + 1] = 1;
                    end
                    slot_order[off >> MINO] = 4'(k);
                    slot_live[off >> MINO] = 1;
                    ra = 10'(off + HDR);
                    rok = 1;
                    live_addrs.push_back(ra);
                end
            end
        end else if (addr >= HDR && addr - HDR < (1 << POOL)
                     && ((addr - HDR) % (1 << MINO)) == 0
                     && slot_live[(addr - HDR) >> MINO]) begin
            off = addr - HDR;
            slot_live[off >> MINO] = 0;
            k = slot_order[off >> MINO];
            lvl = k - MINO;
            while (lvl + 1 < LEVELS) begin
                mate = off ^ (1 << k);
                if (!free_bits[lvl][mate >> k]) break;
                free_bits[lvl][mate >> k] = 0;
                off &= ~(1 << k);
                k++;
                lvl++;
            end
            free_bits[lvl][off >> k] = 1;
            rok = 1;
            foreach (live_addrs[i])
                if (live_addrs[i] == addr) begin
                    live_addrs.delete(i);
                    break;
                end
        end
        exp_addr_q.push_back(ra);
        exp_ok_q.push_back(rok);
    endfunction

    function void check_result(bit [9:0] a, bit ok);
        if (exp_addr_q.size() == 0) begin
            $display("%0t: unexpected result addr %0d ok %0d", $time, a, ok);
            errors++;
        end else begin
            bit [9:0] ea;
            bit eo;
            ea = exp_addr_q.pop_front();
            eo = exp_ok_q.pop_front();
            if (ea !== a) begin
                $display("%0t: block_addr expected %0d actual %0d", $time, ea, a);
                errors++;
            end
            if (eo !== ok) begin
                $display("%0t: ok expected %0d actual %0d", $time, eo, ok);
                errors++;
            end
        end
    endfunction
endclass

module tb_buddy_block_allocator;
    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_req_valid = 0;
    logic       o_req_ready;
    logic       i_req_type = 0;
    logic [9:0] i_req_size = 0;
    logic [9:0] i_free_addr = 0;
    logic       o_rsp_valid;
    logic       i_rsp_ready = 0;
    logic [9:0] o_block_addr;
    logic       o_ok;
    alloc_scoreboard board;
    int         cycles = 0;
    bit         stim_done = 0;

    buddy_block_allocator DUT (.*);

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
        return $urandom_range(0, 3);
    endfunction

    task automatic send_request(bit is_free, bit [9:0] size, bit [9:0] addr);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_req_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_req_valid <= 1;
        i_req_type <= is_free;
        i_req_size <= size;
        i_free_addr <= addr;
        do @(posedge i_clk); while (!o_req_ready);
        board.note_request(is_free, size, addr);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_req_valid <= 0;
        @(negedge i_clk);
        while (board.exp_ok_q.size() > 0) @(negedge i_clk);
    endtask

    task automatic free_random_live();
        bit [9:0] a;
        if (board.live_addrs.size() == 0) a = 10'($urandom);
        else a = board.live_addrs[$urandom_range(0, board.live_addrs.size() - 1)];
        send_request(1, 10'($urandom), a);
    endtask

    always @(posedge i_clk) begin
        cycles++;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) board.check_result(o_block_addr, o_ok);
        if (cycles > 3000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (stim_done && $urandom_range(0, 1)) i_rsp_ready <= 1;
        else if ($urandom_range(0, 29) == 0) i_rsp_ready <= 0;
        else if ($urandom_range(0, 3) == 0) i_rsp_ready <= 1'($urandom_range(0, 1));
        else i_rsp_ready <= 1;
    end

    initial begin
        int r;
        board = new();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        send_request(0, 10'd1016, 0);
        send_request(1, 0, 10'd8);
        send_request(0, 10'd1017, 0);
        send_request(0, 10'd1023, 0);
        send_request(0, 10'd0, 0);
        send_request(0, 10'd1, 0);
        send_request(1, 0, 10'd0);
        send_request(1, 0, 10'd7);
        send_request(1, 0, 10'd9);
        send_request(1, 0, 10'd1023);
        send_request(1, 0, 10'd12);
        send_request(1, 0, 10'd10);
        send_request(1, 0, 10'd10);
        send_request(1, 0, 10'd8);
        for (int i = 0; i < 10; i++) send_request(0, 10'd100, 0);
        while (board.live_addrs.size() > 0) free_random_live();
        drain();
        for (int i = 0; i < 950; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(0, 10'($urandom), 10'($urandom));
                else send_request(0, 10'($urandom_range(0, 120)), 10'($urandom));
            end else if (r < 90) free_random_live();
            else send_request(1, 10'($urandom), 10'($urandom));
            if (i == 500)
                drain();
        end
        stim_done = 1;
        drain();
        repeat (50) @(negedge i_clk);
        if (board.errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_datapath.sv
rtl/buddy_block_allocator.sv
tb/sv/tb_buddy_block_allocator.sv
